/* src/mfb_pkg.sv */
// ----------------------------------------------------------------------------
// mfb_pkg
// shared constants for the max flow engine
// ----------------------------------------------------------------------------
package mfb_pkg;
  localparam int MAX_NODES_DEF = 16;
  localparam int MAX_EDGES_DEF = 32;
  localparam int CAP_BITS_DEF  = 16;
  localparam int NODE_W  = 4;
  localparam int CNT_W   = 5;
  localparam int FIELD_W = 16;
  localparam int TOT_W   = 21;
  localparam int CFG_W   = 5;
  localparam int IDX_W   = 5;
  localparam int KIND_W  = 2;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_SOURCE     = 2'd1;
  localparam logic [1:0] REG_TARGET     = 2'd2;
endpackage

/* src/max_flow_bfs_augmenting.sv */
// ----------------------------------------------------------------------------
// max_flow_bfs_augmenting
// breadth-first augmenting path maximum flow over a loaded edge table
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy is low. load, clear and the
// unused kind finish in the accepting cycle and leave busy low. a run first
// zeroes the flows, one edge at a time, then repeats rounds: seed the search,
// per dequeued node scan the edges one at a time, check the target, then walk
// the path from the target back to the source once for the bottleneck and
// once for the update. after the last round the cut sum is taken over every
// edge and the results follow one per cycle on strobe, one per edge (a
// single totals-only result for an empty table). run length is data
// dependent.
// there is no back pressure: the receiver must take every result as it comes.
module max_flow_bfs_augmenting #(
  parameter int MAX_NODES = mfb_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = mfb_pkg::MAX_EDGES_DEF,
  parameter int CAP_BITS  = mfb_pkg::CAP_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [mfb_pkg::KIND_W-1:0] kind,
  input  logic [mfb_pkg::NODE_W-1:0] from_node,
  input  logic [mfb_pkg::NODE_W-1:0] to_node,
  input  logic [mfb_pkg::FIELD_W-1:0] capacity,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [mfb_pkg::CFG_W-1:0] cfg_data,
  output logic strobe,
  output logic [mfb_pkg::IDX_W-1:0] edge_index,
  output logic [mfb_pkg::FIELD_W-1:0] edge_flow,
  output logic in_cut,
  output logic [mfb_pkg::TOT_W-1:0] max_flow,
  output logic [mfb_pkg::TOT_W-1:0] cut_capacity,
  output logic edge_valid,
  output logic last
);
  import mfb_pkg::*;

  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int NW = $clog2(MAX_NODES);
  localparam int QW = $clog2(MAX_NODES + 1);
  localparam int RW = CAP_BITS + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_ZERO, S_INIT, S_DEQ, S_SCAN, S_CHECK, S_NECK, S_PUSH, S_CUT, S_EMIT
  } state_t;
  state_t state;

  logic [4:0] node_count;
  logic [3:0] source_node, target_node;

  // edge table, registers read combinationally at the signal-chosen addresses k and pk
  logic [NODE_W-1:0]   tail_mem [MAX_EDGES];
  logic [NODE_W-1:0]   head_mem [MAX_EDGES];
  logic [CAP_BITS-1:0] cap_mem  [MAX_EDGES];
  logic [CAP_BITS-1:0] flow_mem [MAX_EDGES];
  logic [ECW-1:0]      edge_count;

  logic [MAX_NODES-1:0] visited;
  logic [EW:0]          parent [MAX_NODES];
  logic [NW-1:0]        queue  [MAX_NODES];
  logic [QW-1:0]        qh, qt;
  logic [NW-1:0]        u;
  logic [EW-1:0]        k;
  logic [NW-1:0]        v;
  logic [QW-1:0]        steps;
  logic [RW-1:0]        neck;
  logic [TOT_W-1:0]     total, cutsum;

  // effective node count
  logic [8:0] n;
  always_comb begin
    if (node_count == '0) n = 9'd1;
    else if (32'(node_count) > MAX_NODES) n = 9'(MAX_NODES);
    else n = 9'(node_count);
  end

  logic [NODE_W-1:0]   et, eh;
  logic [CAP_BITS-1:0] ec, ef;
  logic act, fwd_ok, rev_ok;
  assign et = tail_mem[k];
  assign eh = head_mem[k];
  assign ec = cap_mem[k];
  assign ef = flow_mem[k];
  assign act = (9'(et) < n) && (9'(eh) < n);
  assign fwd_ok = act && (et == NODE_W'(u)) && (ef < ec) && !visited[NW'(eh)];
  assign rev_ok = act && (eh == NODE_W'(u)) && (ef != '0) && !visited[NW'(et)];
  logic last_edge;
  assign last_edge = (ECW'(k) + 1'b1 == edge_count);

  // walk: parent arc of v
  logic [EW:0] arc;
  logic [EW-1:0] pk;
  logic [RW-1:0] pres;
  assign arc = parent[v];
  assign pk = arc[EW:1];
  assign pres = arc[0] ? {1'b0, flow_mem[pk]} : ({1'b0, cap_mem[pk]} - {1'b0, flow_mem[pk]});
  logic src_ok, tgt_ok, walk_done;
  assign src_ok = 9'(source_node) < n;
  assign tgt_ok = (9'(target_node) < n) && (target_node != source_node);
  assign walk_done = (v == NW'(source_node)) || (9'(steps) >= n);

  // search seed: only the source is marked, nothing when it is out of range
  logic [MAX_NODES-1:0] src_mask;
  assign src_mask = src_ok ? (MAX_NODES'(1) << NW'(source_node)) : '0;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      strobe <= 1'b0;
      node_count <= 5'd16; source_node <= 4'd0; target_node <= 4'd1;
      edge_count <= '0; visited <= '0; total <= '0;
    end else begin
      strobe <= (state == S_EMIT);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NODE_COUNT: node_count <= cfg_data;
          REG_SOURCE:     source_node <= cfg_data[3:0];
          REG_TARGET:     target_node <= cfg_data[3:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (start) begin
          if (kind == KIND_LOAD) begin
            if (9'(from_node) < n && 9'(to_node) < n && 32'(edge_count) < MAX_EDGES) begin
              tail_mem[EW'(edge_count)] <= from_node;
              head_mem[EW'(edge_count)] <= to_node;
              cap_mem[EW'(edge_count)] <= CAP_BITS'(capacity);
              edge_count <= edge_count + 1'b1;
            end
          end else if (kind == KIND_CLEAR) begin
            edge_count <= '0; total <= '0;
          end else if (kind == KIND_RUN) begin
            k <= '0; total <= '0;
            state <= (edge_count == '0) ? S_INIT : S_ZERO;
          end
        end
        S_ZERO: begin
          // flows restart from zero, one edge per cycle
          flow_mem[k] <= '0;
          if (last_edge) state <= S_INIT; else k <= k + 1'b1;
        end
        S_INIT: begin
          visited <= src_mask;
          qh <= '0;
          qt <= src_ok ? QW'(1) : '0;
          queue[0] <= NW'(source_node);
          state <= src_ok ? S_DEQ : S_CHECK;
        end
        S_DEQ: begin
          if (qh < qt && edge_count != '0) begin
            u <= queue[NW'(qh)]; qh <= qh + 1'b1; k <= '0; state <= S_SCAN;
          end else state <= S_CHECK;
        end
        S_SCAN: begin
          // forward then reverse arc share this cycle: both cannot fire for
          // the same node unless a self loop, which visited excludes
          if (fwd_ok) begin
            visited[NW'(eh)] <= 1'b1; parent[NW'(eh)] <= {k, 1'b0};
            if (32'(qt) < MAX_NODES) begin queue[NW'(qt)] <= NW'(eh); qt <= qt + 1'b1; end
          end else if (rev_ok) begin
            visited[NW'(et)] <= 1'b1; parent[NW'(et)] <= {k, 1'b1};
            if (32'(qt) < MAX_NODES) begin queue[NW'(qt)] <= NW'(et); qt <= qt + 1'b1; end
          end
          if (last_edge) state <= S_DEQ; else k <= k + 1'b1;
        end
        S_CHECK: begin
          if (tgt_ok && visited[NW'(target_node)]) begin
            v <= NW'(target_node); steps <= '0; neck <= '1;
            state <= S_NECK;
          end else begin
            k <= '0; cutsum <= '0;
            state <= (edge_count == '0) ? S_EMIT : S_CUT;
          end
        end
        S_NECK: begin
          // bottleneck walk from the target back to the source
          if (walk_done) begin
            v <= NW'(target_node); steps <= '0;
            if (neck == '0 || neck == '1) state <= S_INIT;
            else state <= S_PUSH;
          end else begin
            if (pres < neck) neck <= pres;
            v <= arc[0] ? NW'(head_mem[pk]) : NW'(tail_mem[pk]);
            steps <= steps + 1'b1;
          end
        end
        S_PUSH: begin
          if (walk_done) begin
            total <= total + TOT_W'(neck);
            state <= S_INIT;
          end else begin
            if (arc[0]) begin
              flow_mem[pk] <= flow_mem[pk] - CAP_BITS'(neck);
              v <= NW'(head_mem[pk]);
            end else begin
              flow_mem[pk] <= flow_mem[pk] + CAP_BITS'(neck);
              v <= NW'(tail_mem[pk]);
            end
            steps <= steps + 1'b1;
          end
        end
        S_CUT: begin
          if (act && visited[NW'(et)] && !visited[NW'(eh)]) cutsum <= cutsum + TOT_W'(ec);
          if (last_edge) begin k <= '0; state <= S_EMIT; end else k <= k + 1'b1;
        end
        S_EMIT: begin
          max_flow <= total;
          cut_capacity <= cutsum;
          if (edge_count == '0) begin
            edge_index <= '0; edge_flow <= '0; in_cut <= 1'b0;
            edge_valid <= 1'b0; last <= 1'b1; state <= S_IDLE;
          end else begin
            edge_index <= IDX_W'(k);
            edge_flow <= act ? FIELD_W'(ef) : '0;
            in_cut <= act && visited[NW'(et)] && !visited[NW'(eh)];
            edge_valid <= 1'b1;
            last <= last_edge;
            if (last_edge) state <= S_IDLE; else k <= k + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst) strobe |-> $past(busy))
    else $error("result without run");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> busy) else $error("scan while idle");
endmodule

/* test/tb_max_flow_bfs_augmenting.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_flow_bfs_augmenting
// self-checking bench for the breadth-first augmenting path max flow engine
// ----------------------------------------------------------------------------
// a directed table covers the empty table, the ignored kind, capacity extremes,
// dropped loads, an out of range source, source equal to target and shrinking node counts.
// random graphs follow: clear, loads, run, under several idle patterns. every
// run is predicted by an in-bench edmonds-karp solver and each streamed edge
// report is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_max_flow_bfs_augmenting;
  import mfb_pkg::*;

  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
  localparam int NODES = MAX_NODES_DEF;
  localparam int EDGES = MAX_EDGES_DEF;
  localparam int RANDOM_ITEMS = 210;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [FIELD_W-1:0] flow;
    logic               cut;
    logic [TOT_W-1:0]   total;
    logic [TOT_W-1:0]   cut_cap;
    logic               valid;
    logic               fin;
  } edge_report_t;

  // one line of the directed table: either a register write or a request
  typedef struct {
    bit                 is_cfg;
    logic [1:0]         reg_sel;
    logic [CFG_W-1:0]   reg_val;
    logic [KIND_W-1:0]  op;
    logic [NODE_W-1:0]  tail;
    logic [NODE_W-1:0]  head;
    logic [FIELD_W-1:0] cap;
    bit                 typed;
    edge_report_t       want;
  } script_row_t;

  logic clk, rst, start, busy;
  logic [KIND_W-1:0]  kind;
  logic [NODE_W-1:0]  from_node, to_node;
  logic [FIELD_W-1:0] capacity;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic strobe;
  logic [IDX_W-1:0] edge_index;
  logic [FIELD_W-1:0] edge_flow;
  logic in_cut;
  logic [TOT_W-1:0] max_flow, cut_capacity;
  logic edge_valid, last;

  max_flow_bfs_augmenting DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .from_node(from_node), .to_node(to_node), .capacity(capacity),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .edge_index(edge_index), .edge_flow(edge_flow),
    .in_cut(in_cut), .max_flow(max_flow), .cut_capacity(cut_capacity),
    .edge_valid(edge_valid), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // shadow of the engine: registers, edge table and flows
  logic [4:0]         sh_nodes;
  logic [3:0]         sh_src, sh_dst;
  logic [3:0]         tbl_tail [EDGES];
  logic [3:0]         tbl_head [EDGES];
  logic [15:0]        tbl_cap  [EDGES];
  longint unsigned    tbl_flow [EDGES];
  int                 tbl_count;
  bit                 reached  [NODES];
  int                 via_arc  [NODES];
  longint unsigned    pushed_total;

  edge_report_t pending_reports [$];
  int  fail_count;
  int  gap_pct;
  int  requests_sent;
  script_row_t script [$];

  function automatic int active_nodes();
    if (sh_nodes == 0) return 1;
    if (sh_nodes > NODES) return NODES;
    return sh_nodes;
  endfunction

  function automatic bit edge_live(int k, int n);
    return tbl_tail[k] < n && tbl_head[k] < n;
  endfunction

  // breadth-first search of the residual graph, forward arc before reverse arc
  function automatic bit find_path(int n);
    int fifo [NODES];
    int qh, qt, u;
    qh = 0;
    qt = 0;
    foreach (reached[i]) reached[i] = 1'b0;
    if (sh_src >= n) return 1'b0;
    reached[sh_src] = 1'b1;
    fifo[qt++] = sh_src;
    while (qh < qt) begin
      u = fifo[qh++];
      for (int k = 0; k < tbl_count; k++) begin
        if (!edge_live(k, n)) continue;
        if (tbl_tail[k] == u && tbl_flow[k] < tbl_cap[k] && !reached[tbl_head[k]]) begin
          reached[tbl_head[k]] = 1'b1;
          via_arc[tbl_head[k]] = 2 * k;
          if (qt < NODES) fifo[qt++] = tbl_head[k];
        end
        if (tbl_head[k] == u && tbl_flow[k] > 0 && !reached[tbl_tail[k]]) begin
          reached[tbl_tail[k]] = 1'b1;
          via_arc[tbl_tail[k]] = 2 * k + 1;
          if (qt < NODES) fifo[qt++] = tbl_tail[k];
        end
      end
    end
    return sh_dst < n && sh_dst != sh_src && reached[sh_dst];
  endfunction

  // push the bottleneck back along the recorded parent arcs
  function automatic void push_path(int n);
    longint unsigned neck, r;
    int v, steps, k;
    neck = '1;
    v = sh_dst;
    steps = 0;
    while (v != sh_src && steps < n) begin
      k = (via_arc[v] >> 1) % EDGES;
      r = via_arc[v][0] ? tbl_flow[k] : tbl_cap[k] - tbl_flow[k];
      if (r < neck) neck = r;
      v = via_arc[v][0] ? tbl_head[k] : tbl_tail[k];
      steps++;
    end
    if (neck == 0 || neck == '1) return;
    v = sh_dst;
    steps = 0;
    while (v != sh_src && steps < n) begin
      k = (via_arc[v] >> 1) % EDGES;
      if (via_arc[v][0]) begin
        tbl_flow[k] -= neck;
        v = tbl_head[k];
      end else begin
        tbl_flow[k] += neck;
        v = tbl_tail[k];
      end
      steps++;
    end
    pushed_total += neck;
  endfunction

  // apply one accepted request to the shadow, queue the edge reports it causes
  function automatic void predict_request(logic [KIND_W-1:0] op, logic [3:0] f,
                                          logic [3:0] t, logic [15:0] c);
    int n, guard;
    longint unsigned cut_sum;
    edge_report_t rep;
    n = active_nodes();
    case (op)
      KIND_LOAD: begin
        if (f < n && t < n && tbl_count < EDGES) begin
          tbl_tail[tbl_count] = f;
          tbl_head[tbl_count] = t;
          tbl_cap[tbl_count]  = c;
          tbl_flow[tbl_count] = 0;
          tbl_count++;
        end
      end
      KIND_CLEAR: begin
        tbl_count = 0;
        pushed_total = 0;
      end
      KIND_RUN: begin
        for (int k = 0; k < tbl_count; k++) tbl_flow[k] = 0;
        pushed_total = 0;
        guard = 0;
        while (find_path(n) && guard < 1000000) begin
          push_path(n);
          guard++;
        end
        // reached[] now marks the source side of the minimum cut
        cut_sum = 0;
        for (int k = 0; k < tbl_count; k++)
          if (edge_live(k, n) && reached[tbl_tail[k]] && !reached[tbl_head[k]])
            cut_sum += tbl_cap[k];
        if (tbl_count == 0) begin
          rep = '0;
          rep.total = pushed_total[TOT_W-1:0];
          rep.cut_cap = cut_sum[TOT_W-1:0];
          rep.fin = 1'b1;
          pending_reports.push_back(rep);
        end
        for (int k = 0; k < tbl_count; k++) begin
          rep.idx     = k[IDX_W-1:0];
          rep.flow    = edge_live(k, n) ? tbl_flow[k][15:0] : '0;
          rep.cut     = edge_live(k, n) && reached[tbl_tail[k]] && !reached[tbl_head[k]];
          rep.total   = pushed_total[TOT_W-1:0];
          rep.cut_cap = cut_sum[TOT_W-1:0];
          rep.valid   = 1'b1;
          rep.fin     = (k + 1 == tbl_count);
          pending_reports.push_back(rep);
        end
      end
      default: ;
    endcase
  endfunction

  // scoreboard: every strobe is matched with the oldest pending report
  always @(posedge clk) begin
    edge_report_t exp_rep;
    if (!rst && strobe) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected edge report, index %0d", edge_index);
        fail_count++;
      end else begin
        exp_rep = pending_reports.pop_front();
        if (edge_index !== exp_rep.idx) begin
          $error("edge_index expected %0d actual %0d", exp_rep.idx, edge_index);
          fail_count++;
        end
        if (edge_flow !== exp_rep.flow) begin
          $error("edge_flow expected %0d actual %0d", exp_rep.flow, edge_flow);
          fail_count++;
        end
        if (in_cut !== exp_rep.cut) begin
          $error("in_cut expected %0d actual %0d", exp_rep.cut, in_cut);
          fail_count++;
        end
        if (max_flow !== exp_rep.total) begin
          $error("max_flow expected %0d actual %0d", exp_rep.total, max_flow);
          fail_count++;
        end
        if (cut_capacity !== exp_rep.cut_cap) begin
          $error("cut_capacity expected %0d actual %0d", exp_rep.cut_cap, cut_capacity);
          fail_count++;
        end
        if (edge_valid !== exp_rep.valid) begin
          $error("edge_valid expected %0d actual %0d", exp_rep.valid, edge_valid);
          fail_count++;
        end
        if (last !== exp_rep.fin) begin
          $error("last expected %0d actual %0d", exp_rep.fin, last);
          fail_count++;
        end
      end
    end
  end

  // random sender gaps, start low meanwhile
  task automatic sender_gap();
    int cycles;
    if (gap_pct == 0 || $urandom_range(99, 0) >= gap_pct) return;
    cycles = $urandom_range(4, 1);
    repeat (cycles) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // drive a request at the falling edge and hold it until taken while busy is low
  task automatic send_request(logic [KIND_W-1:0] op, logic [3:0] f, logic [3:0] t,
                              logic [15:0] c, bit use_model);
    sender_gap();
    @(negedge clk);
    start = 1'b1;
    kind = op;
    from_node = f;
    to_node = t;
    capacity = c;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    if (use_model) predict_request(op, f, t, c);
    if (op != KIND_NOP) requests_sent++;
  endtask

  // wait until every report is in and the engine has gone quiet
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    wait (pending_reports.size() == 0);
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    repeat (4) @(posedge clk);
  endtask

  // register writes only happen with the engine idle
  task automatic write_reg(logic [1:0] sel, logic [CFG_W-1:0] val);
    wait_idle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = sel;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (sel)
      REG_NODE_COUNT: sh_nodes = val;
      REG_SOURCE:     sh_src = val[3:0];
      REG_TARGET:     sh_dst = val[3:0];
      default: ;
    endcase
  endtask

  task automatic add_row(bit is_cfg, logic [1:0] sel, logic [CFG_W-1:0] val,
                         logic [KIND_W-1:0] op, logic [3:0] f, logic [3:0] t,
                         logic [15:0] c);
    script_row_t row;
    row = '{default: '0};
    row.is_cfg = is_cfg;
    row.reg_sel = sel;
    row.reg_val = val;
    row.op = op;
    row.tail = f;
    row.head = t;
    row.cap = c;
    script.push_back(row);
  endtask

  function automatic logic [15:0] random_cap();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 50) return 16'($urandom_range(20, 1));
    if (pick < 90) return 16'($urandom_range(65535, 0));
    return pick[0] ? 16'hFFFF : 16'h0000;
  endfunction

  // one random graph: optional reconfigure, clear, loads, noise, optional shrink, run, sometimes a second run
  task automatic random_graph();
    int n, edges, pick;
    logic [3:0] f, t;
    pick = $urandom_range(99, 0);
    if (pick < 30) begin
      if (pick < 10) write_reg(REG_NODE_COUNT, CFG_W'($urandom_range(31, 0)));
      else write_reg(REG_NODE_COUNT, CFG_W'($urandom_range(16, 2)));
      n = active_nodes();
      if (pick < 5) begin
        write_reg(REG_SOURCE, CFG_W'($urandom_range(15, 0)));
        write_reg(REG_TARGET, CFG_W'($urandom_range(15, 0)));
      end else begin
        write_reg(REG_SOURCE, CFG_W'($urandom_range(n - 1, 0)));
        write_reg(REG_TARGET, CFG_W'($urandom_range(n - 1, 0)));
      end
    end
    n = active_nodes();
    send_request(KIND_CLEAR, 4'($urandom), 4'($urandom), 16'($urandom), 1'b1);
    // now and then overfill the table so trailing loads are dropped
    edges = ($urandom_range(11, 0) == 0) ? 34 : $urandom_range(10, 1);
    for (int i = 0; i < edges; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 8) begin
        f = 4'($urandom);
        t = 4'($urandom);
      end else begin
        f = 4'($urandom_range(n - 1, 0));
        t = 4'($urandom_range(n - 1, 0));
      end
      if (pick >= 92) send_request(KIND_NOP, f, t, random_cap(), 1'b1);
      send_request(KIND_LOAD, f, t, random_cap(), 1'b1);
    end
    // shrinking the node count strands some loaded edges
    if ($urandom_range(9, 0) == 0 && n > 2)
      write_reg(REG_NODE_COUNT, CFG_W'($urandom_range(n - 1, 1)));
    send_request(KIND_RUN, 4'($urandom), 4'($urandom), 16'($urandom), 1'b1);
    if ($urandom_range(7, 0) == 0)
      send_request(KIND_RUN, 4'($urandom), 4'($urandom), 16'($urandom), 1'b1);
  endtask

  initial begin
    script_row_t row;
    int phase_goal;
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_LOAD;
    from_node = '0;
    to_node = '0;
    capacity = '0;
    cfg_we = 1'b0;
    cfg_index = REG_NODE_COUNT;
    cfg_data = '0;
    fail_count = 0;
    gap_pct = 0;
    requests_sent = 0;
    sh_nodes = 5'd16;
    sh_src = 4'd0;
    sh_dst = 4'd1;
    tbl_count = 0;
    pushed_total = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part
    // run on an empty table after reset: a single totals-only report
    add_row(0, REG_NODE_COUNT, 0, KIND_RUN, 0, 0, 0);
    script[$].typed = 1'b1;
    script[$].want = '{idx: 0, flow: 0, cut: 0, total: 0, cut_cap: 0, valid: 0, fin: 1};
    add_row(0, REG_NODE_COUNT, 0, KIND_NOP, 4'hF, 4'hF, 16'hFFFF);
    // one full-capacity edge from source to sink is the whole cut
    add_row(0, REG_NODE_COUNT, 0, KIND_LOAD, 0, 1, 16'hFFFF);
    add_row(0, REG_NODE_COUNT, 0, KIND_RUN, 0, 0, 0);
    script[$].typed = 1'b1;
    script[$].want = '{idx: 0, flow: 16'hFFFF, cut: 1, total: 21'd65535,
                       cut_cap: 21'd65535, valid: 1, fin: 1};
    // diamond with a cross edge
    add_row(0, REG_NODE_COUNT, 0, KIND_CLEAR, 0, 0, 0);
    add_row(0, REG_NODE_COUNT, 0, KIND_LOAD, 0, 2, 16'd1);
    add_row(0, REG_NODE_COUNT, 0, KIND_LOAD, 0, 3, 16'd1);
    add_row(0, REG_NODE_COUNT, 0, KIND_LOAD, 2, 3, 16'd1);
    add_row(0, REG_NODE_COUNT, 0, KIND_LOAD, 2, 1, 16'd1);
    add_row(0, REG_NODE_COUNT, 0, KIND_LOAD, 3, 1, 16'd1);
    add_row(0, REG_NODE_COUNT, 0, KIND_LOAD, 15, 0, 16'd0);
    add_row(0, REG_NODE_COUNT, 0, KIND_RUN, 0, 0, 0);
    // fewer nodes strand the upper edges, the repeat run restarts flows
    add_row(1, REG_NODE_COUNT, 5'd3, KIND_LOAD, 0, 0, 0);
    add_row(0, REG_NODE_COUNT, 0, KIND_LOAD, 0, 7, 16'd9);
    add_row(0, REG_NODE_COUNT, 0, KIND_RUN, 0, 0, 0);
    // source out of range, then source equal to target
    add_row(1, REG_SOURCE, 5'd15, KIND_LOAD, 0, 0, 0);
    add_row(0, REG_NODE_COUNT, 0, KIND_RUN, 0, 0, 0);
    add_row(1, REG_NODE_COUNT, 5'd31, KIND_LOAD, 0, 0, 0);
    add_row(1, REG_TARGET, 5'd15, KIND_LOAD, 0, 0, 0);
    add_row(0, REG_NODE_COUNT, 0, KIND_RUN, 0, 0, 0);
    add_row(1, REG_SOURCE, 5'd0, KIND_LOAD, 0, 0, 0);
    add_row(1, REG_TARGET, 5'd0, KIND_LOAD, 0, 0, 0);
    add_row(0, REG_NODE_COUNT, 0, KIND_RUN, 0, 0, 0);
    // a zero node count acts as one node: only self loops load
    add_row(1, REG_NODE_COUNT, 5'd0, KIND_LOAD, 0, 0, 0);
    add_row(0, REG_NODE_COUNT, 0, KIND_LOAD, 0, 0, 16'd7);
    add_row(0, REG_NODE_COUNT, 0, KIND_LOAD, 1, 0, 16'd7);
    add_row(0, REG_NODE_COUNT, 0, KIND_RUN, 0, 0, 0);

    foreach (script[i]) begin
      row = script[i];
      if (row.is_cfg) begin
        write_reg(row.reg_sel, row.reg_val);
      end else begin
        send_request(row.op, row.tail, row.head, row.cap, !row.typed);
        if (row.typed) begin
          pending_reports.push_back(row.want);
          predict_request(row.op, row.tail, row.head, row.cap);
          void'(pending_reports.pop_back());
        end
      end
    end

    // random part: phases of no idling, heavy sender gaps, none, light gaps
    write_reg(REG_NODE_COUNT, 5'd16);
    write_reg(REG_SOURCE, 5'd0);
    write_reg(REG_TARGET, 5'd1);
    requests_sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = (ph == 1) ? 72 : (ph == 3) ? 10 : 0;
      phase_goal = (ph + 1) * RANDOM_ITEMS / 4;
      // sender holds off until the engine has delivered everything
      if (ph == 2) wait_idle();
      while (requests_sent < phase_goal) random_graph();
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hard stop if the engine hangs
  initial begin
    #400ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* max_flow_bfs_augmenting.f */
src/mfb_pkg.sv
src/max_flow_bfs_augmenting.sv
test/tb_max_flow_bfs_augmenting.sv
